>>> design/hhm_pkg.sv
// shared types, codes and constants of the task heartbeat health monitor
package hhm_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int OP_W     = 3;
  localparam int ID_W     = 16;
  localparam int IVL_W    = 24;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int HEALTH_W = 2;
  localparam int STUCK_W  = 8;

  localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
  localparam logic [OP_W-1:0] OP_HEARTBEAT  = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK      = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT  = 3'd4;

  localparam logic [HEALTH_W-1:0] H_OK       = 2'd0;
  localparam logic [HEALTH_W-1:0] H_STUCK    = 2'd1;
  localparam logic [HEALTH_W-1:0] H_NOT_RESP = 2'd2;

  localparam logic [STUCK_W-1:0] STUCK_MAX = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd31;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [IVL_W-1:0]    ivl;
    logic [TIME_W-1:0]   last;
    logic [HEALTH_W-1:0] health;
    logic [STUCK_W-1:0]  stuck;
  } entry_t;

  // strobes and operands broadcast to every cell
  typedef struct packed {
    logic              append;
    logic              remove;
    logic              beat;
    logic              check;
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  ivl;
    logic [TIME_W-1:0] now;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

>>> design/hhm_if.sv
// request, response and configuration channel interfaces
interface hhm_req_if
  import hhm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ID_W-1:0]   task_id;
  logic [IVL_W-1:0]  interval_ms;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output opcode, output task_id, output interval_ms,
                  output now_ms, input ready);
  modport sink (input valid, input opcode, input task_id, input interval_ms,
                input now_ms, output ready);
endinterface

interface hhm_rsp_if
  import hhm_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status_code;
  logic [COUNT_W-1:0]  overdue_count;
  logic [HEALTH_W-1:0] health_state;
  logic [STUCK_W-1:0]  stuck_events;
  logic [TIME_W-1:0]   last_beat_ms;
  logic [IVL_W-1:0]    expected_ms;
  logic [COUNT_W-1:0]  tasks_monitored;

  modport source (output valid, output status_code, output overdue_count,
                  output health_state, output stuck_events, output last_beat_ms,
                  output expected_ms, output tasks_monitored, input ready);
  modport sink (input valid, input status_code, input overdue_count,
                input health_state, input stuck_events, input last_beat_ms,
                input expected_ms, input tasks_monitored, output ready);
endinterface

interface hhm_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/hhm_cell.sv
// one table entry: id match, elapsed-time checks and shift from the upper neighbor
module hhm_cell
  import hhm_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      at_tail,
  input  entry_t    nbr_entry,
  input  logic      shift_in,
  output logic      shift_out,
  output logic      match,
  output logic      unhealthy,
  output entry_t    entry
);

  entry_t            entry_next;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] limit2;
  logic [TIME_W-1:0] limit5;
  logic              over2;
  logic              over5;

  assign match     = occupied && (entry.id == ctl.id);
  assign shift_out = shift_in | match;

  // intervals are 24 bits, so 2x and 5x never wrap in 32 bits
  assign elapsed = ctl.now - entry.last;
  assign limit2  = TIME_W'({entry.ivl, 1'b0});
  assign limit5  = TIME_W'({entry.ivl, 2'b00}) + TIME_W'(entry.ivl);
  assign over2   = elapsed > limit2;
  assign over5   = elapsed > limit5;

  assign unhealthy = ctl.check && occupied && over2;

  always_comb begin
    entry_next = entry;
    if (ctl.append && at_tail) begin
      entry_next.id     = ctl.id;
      entry_next.ivl    = ctl.ivl;
      entry_next.last   = ctl.now;
      entry_next.health = H_OK;
      entry_next.stuck  = '0;
    end else if (ctl.remove && shift_out) begin
      // everything at and above the removed entry moves down one place
      entry_next = nbr_entry;
    end else if (ctl.beat && match) begin
      entry_next.last = ctl.now;
      if (entry.health != H_OK) begin
        entry_next.health = H_OK;
        entry_next.stuck  = '0;
      end
    end else if (ctl.check && occupied) begin
      if (over2 && entry.health == H_OK) begin
        entry_next.health = H_STUCK;
        if (entry.stuck != STUCK_MAX) begin
          entry_next.stuck = entry.stuck + STUCK_W'(1);
        end
      end
      if (over5) begin
        entry_next.health = H_NOT_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> design/task_heartbeat_health_monitor_top.sv
// Task heartbeat health monitor: a row of MAX_TASKS entry cells that register, unregister,
// stamp, check and query monitored tasks. Each request transaction gives exactly one
// response transaction. A request is captured in S_IDLE; then, in S_EXEC, every
// cell of the row compares its id and elapsed time in parallel and updates itself, with
// unregister shifting higher entries down by one cell. The response sits in an output
// register, so the next request is captured while a response still waits; a response that
// is not taken holds the row in S_EXEC. The table needs no clearing after reset:
// only entries below the entry count are ever looked at. monitor_enable resets to 1 and is
// written through the cfg channel, which is always ready.
module task_heartbeat_health_monitor_top
  import hhm_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  hhm_req_if.sink   req,
  hhm_rsp_if.source rsp,
  hhm_cfg_if.sink   cfg
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  state_t state;
  state_t state_next;

  logic              monitor_enable;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  count_next;

  logic [OP_W-1:0]   cmd_op;
  logic [ID_W-1:0]   cmd_id;
  logic [IVL_W-1:0]  cmd_ivl;
  logic [TIME_W-1:0] cmd_now;

  logic exec_fire;
  logic rsp_valid;

  logic [MAX_TASKS-1:0] occupied;
  logic [MAX_TASKS-1:0] at_tail;
  logic [MAX_TASKS-1:0] match_vec;
  logic [MAX_TASKS-1:0] unh_vec;
  logic [MAX_TASKS:0]   shift_chain;
  entry_t               cell_entry [MAX_TASKS];
  entry_t               q_entry;
  logic                 any_match;
  logic                 full;

  logic                do_append;
  logic                do_remove;
  logic                do_beat;
  logic                do_check;
  logic                do_query;
  logic [STATUS_W-1:0] status;
  cell_ctl_t           ctl;

  logic [31:0]        unh_total;
  logic [31:0]        cnt_total;
  logic [COUNT_W-1:0] unh_sat;
  logic [COUNT_W-1:0] cnt_sat;

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    exec_fire = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      monitor_enable <= 1'b1;
      entry_count    <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        monitor_enable <= cfg.data;
      end
      if (exec_fire) begin
        entry_count <= count_next;
      end
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_op  <= req.opcode;
      cmd_id  <= req.task_id;
      cmd_ivl <= req.interval_ms;
      cmd_now <= req.now_ms;
    end
  end

  // decode against the current table
  assign any_match = |match_vec;
  assign full      = entry_count >= CNT_W'(MAX_TASKS);

  always_comb begin
    status    = ST_OK;
    do_append = 1'b0;
    do_remove = 1'b0;
    do_beat   = 1'b0;
    do_check  = 1'b0;
    do_query  = 1'b0;
    unique case (cmd_op)
      OP_REGISTER: begin
        if (cmd_id == '0 || cmd_ivl == '0) begin
          status = ST_INVALID;
        end else if (any_match) begin
          status = ST_OK;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          do_append = 1'b1;
        end
      end
      OP_UNREGISTER: begin
        if (!monitor_enable) begin
          status = ST_NOT_INIT;
        end else if (!any_match) begin
          status = ST_NOT_FOUND;
        end else begin
          do_remove = 1'b1;
        end
      end
      OP_HEARTBEAT: begin
        if (!monitor_enable) begin
          status = ST_NOT_INIT;
        end else begin
          do_beat = 1'b1;
        end
      end
      OP_CHECK: begin
        do_check = monitor_enable;
      end
      OP_QUERY: begin
        if (!monitor_enable) begin
          status = ST_INVALID;
        end else if (!any_match) begin
          status = ST_NOT_FOUND;
        end else begin
          do_query = 1'b1;
        end
      end
      default: status = ST_INVALID;
    endcase
  end

  always_comb begin
    count_next = entry_count;
    if (do_append) begin
      count_next = entry_count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = entry_count - CNT_W'(1);
    end
  end

  always_comb begin
    ctl.append = do_append && exec_fire;
    ctl.remove = do_remove && exec_fire;
    ctl.beat   = do_beat && exec_fire;
    ctl.check  = do_check && exec_fire;
    ctl.id     = cmd_id;
    ctl.ivl    = cmd_ivl;
    ctl.now    = cmd_now;
  end

  // cell row
  assign shift_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    entry_t nbr;

    assign occupied[i] = CNT_W'(i) < entry_count;
    assign at_tail[i]  = CNT_W'(i) == entry_count;

    if (i < MAX_TASKS - 1) begin : g_nbr
      assign nbr = cell_entry[i+1];
    end else begin : g_top
      assign nbr = '0;
    end

    hhm_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occupied[i]),
      .at_tail   (at_tail[i]),
      .nbr_entry (nbr),
      .shift_in  (shift_chain[i]),
      .shift_out (shift_chain[i+1]),
      .match     (match_vec[i]),
      .unhealthy (unh_vec[i]),
      .entry     (cell_entry[i])
    );
  end

  // ids in the table are unique, so at most one cell matches
  always_comb begin
    q_entry = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (match_vec[i]) begin
        q_entry = q_entry | cell_entry[i];
      end
    end
  end

  assign unh_total = 32'($countones(unh_vec));
  assign cnt_total = 32'(count_next);
  assign unh_sat   = (unh_total > 32'(COUNT_SAT)) ? COUNT_SAT : unh_total[COUNT_W-1:0];
  assign cnt_sat   = (cnt_total > 32'(COUNT_SAT)) ? COUNT_SAT : cnt_total[COUNT_W-1:0];

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp.status_code     <= status;
      rsp.overdue_count   <= do_check ? unh_sat : '0;
      rsp.health_state    <= do_query ? q_entry.health : '0;
      rsp.stuck_events    <= do_query ? q_entry.stuck : '0;
      rsp.last_beat_ms    <= do_query ? q_entry.last : '0;
      rsp.expected_ms     <= do_query ? q_entry.ivl : '0;
      rsp.tasks_monitored <= cnt_sat;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule
